/* rtl/bfac_pkg.sv */
// Package for the brightness fade controller: operation codes, command and status types.
// Used by bfac_ctrl, bfac_dp and the top level; no dependencies.
`timescale 1ns / 1ps
package bfac_pkg;

  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_SET     = 4'd1;
  localparam logic [3:0] OP_TOGGLE  = 4'd2;
  localparam logic [3:0] OP_PRESET  = 4'd3;
  localparam logic [3:0] OP_FADE    = 4'd4;
  localparam logic [3:0] OP_PULSE   = 4'd5;
  localparam logic [3:0] OP_SAVE    = 4'd6;
  localparam logic [3:0] OP_RESTORE = 4'd7;
  localparam logic [3:0] OP_ARM     = 4'd8;
  localparam logic [3:0] OP_DISARM  = 4'd9;

  localparam logic [1:0] CFG_INVERT  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_DIMLVL  = 2'd2;

  localparam int unsigned DEFAULT_RESTORE = 75;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // latch the request and apply immediate commands
    logic div_start;  // begin the progress division
    logic div_step;   // one restoring division step
    logic mul_a;      // square
    logic mul_b;      // cube
    logic mul_c;      // scale by the level span
    logic finish;     // apply the eased level, then auto-dim check
    logic out_load;   // capture the result registers
  } bfac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_ease;  // this tick needs an eased level
    logic div_done;
  } bfac_sts_t;

endpackage

/* rtl/bfac_ctrl.sv */
// Controller state machine for the brightness fade controller.
// Depends on bfac_pkg; drives the command struct of bfac_dp.
`timescale 1ns / 1ps
module bfac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bfac_pkg::bfac_sts_t sts,
  output bfac_pkg::bfac_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DIV, S_MULA, S_MULB, S_MULC, S_FIN, S_OUT}
    state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // A request is taken in idle once the result slot is free or being emptied.
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.need_ease) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_MULA;
        else cmd.div_step = 1'b1;
      end
      S_MULA: begin cmd.mul_a = 1'b1; state_nxt = S_MULB; end
      S_MULB: begin cmd.mul_b = 1'b1; state_nxt = S_MULC; end
      S_MULC: begin cmd.mul_c = 1'b1; state_nxt = S_FIN; end
      S_FIN:  begin cmd.finish = 1'b1; state_nxt = S_OUT; end
      S_OUT: begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("result not raised after load");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_start_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_DECODE)) else $error("start not followed by decode");
`endif

endmodule

/* rtl/bfac_dp.sv */
// Datapath for the brightness fade controller: state registers, divider, easing multiplies.
// Depends on bfac_pkg; sequenced by bfac_ctrl.
`timescale 1ns / 1ps
module bfac_dp #(
  parameter int unsigned LEVEL_MAX           = 100,
  parameter int unsigned AUTO_DIM_FADE_TICKS = 1000,
  parameter int unsigned PROGRESS_BITS       = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfac_pkg::bfac_cmd_t cmd,
  output bfac_pkg::bfac_sts_t sts,
  input  logic [3:0]          in_operation,
  input  logic [7:0]          in_level,
  input  logic [7:0]          in_level_high,
  input  logic [15:0]         in_duration_ms,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic [6:0]          out_committed_level,
  output logic [6:0]          out_shown_level,
  output logic [7:0]          out_overlay_opacity,
  output logic                out_display_on,
  output logic                out_fading,
  output logic                out_change_notify
);

  localparam int PB = PROGRESS_BITS;
  localparam int DW = PB + 16;  // dividend width
  localparam int CW = $clog2(DW + 1);
  localparam logic [7:0]   LMAX = 8'(LEVEL_MAX);
  localparam logic [7:0]   RST_LVL = (bfac_pkg::DEFAULT_RESTORE > LEVEL_MAX) ?
                                     LMAX : 8'(bfac_pkg::DEFAULT_RESTORE);
  localparam logic [PB:0]  ONE  = (PB+1)'(1) << PB;
  localparam logic [PB:0]  HALF = (PB+1)'(1) << (PB - 1);
  localparam logic [CW-1:0] DIV_N = CW'(DW);
  localparam int unsigned  OPA_SH = 16 + $clog2(LEVEL_MAX);
  localparam logic [16:0]  OPA_RECIP =
    17'(((64'd1 << OPA_SH) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX));

  function automatic logic [7:0] sat(input logic [7:0] v);
    sat = (v > LMAX) ? LMAX : v;
  endfunction

  function automatic logic [7:0] preset(input logic [2:0] i);
    case (i)
      3'd1:    preset = 8'd25;
      3'd2:    preset = 8'd50;
      3'd3:    preset = 8'd75;
      3'd4:    preset = 8'd100;
      default: preset = 8'd0;
    endcase
  endfunction

  // Architectural state; the level registers are 8 bits wide so LEVEL_MAX up to 255 fits.
  logic [7:0]  cur_r, prev_r, saved_r, shown_r, a_start_r, a_tgt_r;
  logic        on_r, active_r, armed_r, pmin_r, notify_r, inv_r;
  logic [15:0] elapsed_r, length_r, timeout_r;
  logic [16:0] idle_r;
  logic [2:0]  pidx_r;
  logic [6:0]  dimlvl_r;
  logic [3:0]  op_r;

  // Division and easing working registers.
  logic [DW-1:0] quo_r;
  logic [16:0]   rem_r;
  logic [CW-1:0] dcnt_r;
  logic [PB:0]   x_r, sq_r, cube_r;
  logic          lowhalf_r;
  logic [PB+8:0] scl_r;

  logic [15:0] elapsed_inc;
  assign elapsed_inc = (elapsed_r < 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

  always_comb begin
    sts.need_ease = (op_r == bfac_pkg::OP_TICK) && active_r && (elapsed_r < length_r);
    sts.div_done  = (dcnt_r == '0);
  end

  // Set-level helper values.
  logic [7:0] set_v;
  logic       do_set;
  logic [2:0] pidx_nxt;
  always_comb begin
    pidx_nxt = (pidx_r == 3'd4) ? 3'd0 : pidx_r + 3'd1;
    do_set   = 1'b1;
    set_v    = 8'd0;
    case (in_operation)
      bfac_pkg::OP_SET:     set_v = sat(in_level);
      bfac_pkg::OP_TOGGLE:  set_v = on_r ? 8'd0 :
                                    sat((prev_r != 8'd0) ? prev_r : 8'(bfac_pkg::DEFAULT_RESTORE));
      bfac_pkg::OP_PRESET:  set_v = sat(preset(pidx_nxt));
      bfac_pkg::OP_RESTORE: set_v = sat(saved_r);
      default:              do_set = 1'b0;
    endcase
  end

  logic [DW-1:0] rem_sh;
  logic [16:0]   rem_try;
  logic [PB:0]   e_val;
  logic [PB+8:0] prod_c;
  logic [7:0]    mag, span;
  always_comb begin
    rem_try = {rem_r[15:0], quo_r[DW-1]} - {1'b0, length_r};
    rem_sh  = {quo_r[DW-2:0], 1'b0};
    e_val   = lowhalf_r ? (cube_r << 2) : (ONE - (cube_r << 2));
    span    = (a_tgt_r >= a_start_r) ? a_tgt_r - a_start_r : a_start_r - a_tgt_r;
    prod_c  = (PB+9)'(span) * (PB+9)'(e_val);
    mag     = 8'(scl_r >> PB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= RST_LVL; prev_r <= RST_LVL;
      saved_r <= RST_LVL; shown_r <= RST_LVL;
      on_r <= 1'b1; active_r <= 1'b0; a_start_r <= '0; a_tgt_r <= '0;
      elapsed_r <= '0; length_r <= '0; armed_r <= 1'b0; idle_r <= '0;
      pidx_r <= '0; pmin_r <= 1'b1; notify_r <= 1'b0;
      inv_r <= 1'b0; timeout_r <= '0; dimlvl_r <= 7'd20; op_r <= '0; dcnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bfac_pkg::CFG_INVERT: begin inv_r <= cfg_data[0]; shown_r <= cur_r; end
          bfac_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
          bfac_pkg::CFG_DIMLVL:  dimlvl_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        op_r     <= in_operation;
        notify_r <= 1'b0;
        if (do_set) begin
          prev_r   <= (in_operation == bfac_pkg::OP_TOGGLE && on_r) ? cur_r : cur_r;
          cur_r    <= set_v;
          shown_r  <= set_v;
          on_r     <= set_v != 8'd0;
          active_r <= 1'b0;
          if (set_v != 8'd0) idle_r <= '0;
          notify_r <= 1'b1;
          if (in_operation == bfac_pkg::OP_PRESET) pidx_r <= pidx_nxt;
        end
        case (in_operation)
          bfac_pkg::OP_TICK: begin
            if (idle_r != 17'h1FFFF) idle_r <= idle_r + 17'd1;
            if (active_r) elapsed_r <= elapsed_inc;
          end
          bfac_pkg::OP_FADE, bfac_pkg::OP_PULSE: begin
            a_start_r <= cur_r;
            a_tgt_r   <= sat((in_operation == bfac_pkg::OP_PULSE && !pmin_r) ?
                             in_level_high : in_level);
            elapsed_r <= '0;
            length_r  <= in_duration_ms;
            active_r  <= 1'b1;
            if (in_operation == bfac_pkg::OP_PULSE) pmin_r <= !pmin_r;
          end
          bfac_pkg::OP_SAVE:   saved_r <= cur_r;
          bfac_pkg::OP_ARM:    begin armed_r <= 1'b1; idle_r <= '0; end
          bfac_pkg::OP_DISARM: armed_r <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.div_start) dcnt_r <= DIV_N;
      else if (cmd.div_step) dcnt_r <= dcnt_r - CW'(1);
      if (cmd.finish && op_r == bfac_pkg::OP_TICK) begin
        if (active_r && elapsed_r >= length_r) begin
          cur_r    <= a_tgt_r;
          shown_r  <= a_tgt_r;
          active_r <= 1'b0;
          notify_r <= 1'b1;
        end else if (active_r) begin
          if (a_tgt_r >= a_start_r)
            shown_r <= sat(8'(9'(a_start_r) + 9'(mag)));
          else
            shown_r <= (mag > a_start_r) ? 8'd0 : a_start_r - mag;
        end
        if (armed_r && on_r && idle_r > {1'b0, timeout_r}) begin
          a_start_r <= (active_r && elapsed_r >= length_r) ? a_tgt_r : cur_r;
          a_tgt_r   <= sat({1'b0, dimlvl_r});
          elapsed_r <= '0;
          length_r  <= 16'(AUTO_DIM_FADE_TICKS);
          active_r  <= 1'b1;
          armed_r   <= 1'b0;
        end
      end
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= {elapsed_r, {PB{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!rem_try[16]) begin
        rem_r <= rem_try;
        quo_r <= {rem_sh[DW-1:1], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], quo_r[DW-1]};
        quo_r <= rem_sh;
      end
    end
    if (cmd.mul_a) begin
      // p < 1 always here since elapsed < length.
      lowhalf_r <= quo_r[PB:0] < HALF;
      x_r       <= (quo_r[PB:0] < HALF) ? quo_r[PB:0] : ONE - quo_r[PB:0];
      sq_r      <= (PB+1)'(((2*PB+2)'(quo_r[PB:0] < HALF ? quo_r[PB:0] : ONE - quo_r[PB:0])
                   * (2*PB+2)'(quo_r[PB:0] < HALF ? quo_r[PB:0] : ONE - quo_r[PB:0])) >> PB);
    end
    if (cmd.mul_b) cube_r <= (PB+1)'(((2*PB+2)'(sq_r) * (2*PB+2)'(x_r)) >> PB);
    if (cmd.mul_c) scl_r  <= prod_c;
  end

  logic [15:0] opa_prod;
  logic [33:0] opa_scaled;
  logic [7:0]  opa;
  always_comb begin
    opa_prod   = 16'(LMAX - sat(shown_r)) * 16'd255;
    // The reciprocal is rounded up, which keeps the quotient exact for any 16-bit product.
    opa_scaled = 34'(opa_prod) * 34'(OPA_RECIP);
    opa        = 8'(opa_scaled >> OPA_SH);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_committed_level <= cur_r[6:0];
      out_shown_level     <= shown_r[6:0];
      out_overlay_opacity <= inv_r ? 8'd255 - opa : opa;
      out_display_on      <= on_r;
      out_fading          <= active_r;
      out_change_notify   <= notify_r;
    end
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (dcnt_r == DIV_N)) else $error("divider count not loaded");
  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmd.out_load) |-> (shown_r <= LMAX)) else $error("shown level above maximum");
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (cur_r <= LMAX)) else $error("committed level above maximum");
`endif

endmodule

/* rtl/brightness_fade_autodim_controller_top.sv */
// Top level of the brightness fade controller: joins bfac_ctrl and bfac_dp.
// Depends on bfac_pkg, bfac_ctrl and bfac_dp.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    operation, level, level_high, duration_ms
//   out_     output     out_valid / out_ready  levels, opacity, flags
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request that needs no easing goes from decode straight to the output state; a tick
// during a fade first runs the bit-serial progress divider and then three registered
// multiplies. One request is in flight at a time.
// Reset is synchronous and active low and restores the power-on levels.
// A result waiting on out_ready holds off the next request until it is taken.
`timescale 1ns / 1ps
module brightness_fade_autodim_controller_top #(
  parameter int unsigned LEVEL_MAX           = 100,
  parameter int unsigned AUTO_DIM_FADE_TICKS = 1000,
  parameter int unsigned PROGRESS_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [7:0]  in_level,
  input  logic [7:0]  in_level_high,
  input  logic [15:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_committed_level,
  output logic [6:0]  out_shown_level,
  output logic [7:0]  out_overlay_opacity,
  output logic        out_display_on,
  output logic        out_fading,
  output logic        out_change_notify,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bfac_pkg::bfac_cmd_t cmd;
  bfac_pkg::bfac_sts_t sts;

  assign cfg_ready = 1'b1;

  bfac_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  bfac_dp #(
    .LEVEL_MAX(LEVEL_MAX), .AUTO_DIM_FADE_TICKS(AUTO_DIM_FADE_TICKS),
    .PROGRESS_BITS(PROGRESS_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_operation, .in_level, .in_level_high, .in_duration_ms,
    .cfg_we(cfg_valid), .cfg_index, .cfg_data,
    .out_committed_level, .out_shown_level, .out_overlay_opacity,
    .out_display_on, .out_fading, .out_change_notify
  );

endmodule
